// ===== rtl/core/indexed_max_heap_queue_assert.svh =====
// Assertion macros for the indexed max-heap queue
`ifndef INDEXED_MAX_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MAX_HEAP_QUEUE_ASSERT_SVH
// implication checked every clock, off during reset
`define IMHQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define IMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/core/imhq_pkg.sv =====
// Shared types and codes for the indexed max-heap queue
package imhq_pkg;
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   // key compare result from the shared compare unit
   typedef struct packed {
      logic gt;
   } cmp_rsp_type;
endpackage

// ===== rtl/core/imhq_cmp.sv =====
// Shared registered key comparator
module imhq_cmp #(
   parameter int KEY_BITS = 32
) (
   input  logic                  clock,
   input  logic [KEY_BITS-1:0]   a_key,
   input  logic [KEY_BITS-1:0]   b_key,
   output imhq_pkg::cmp_rsp_type rsp
);
   imhq_pkg::cmp_rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      rsp_ff.gt <= a_key > b_key;
   end
   assign rsp = rsp_ff;
endmodule

// ===== rtl/core/indexed_max_heap_queue.sv =====
// Indexed max-heap queue: one heap op per command, sequenced over memory ports.
// The rsp_ word strobe follows an unused mode or empty pop directly; a clear first sweeps
// the position map; an insert climbs level by level, an update climbs or else walks down,
// and a pop walks down level by level. One command at a time; the next start is taken
// the cycle after the strobe. Reset (synchronous) empties the heap, then sweeps the
// whole position map with busy high. The receiver cannot stall results.
module indexed_max_heap_queue #(
   parameter int ITEMS    = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_mode,
   input  logic [$clog2(ITEMS)-1:0]     req_item_index,
   input  logic [KEY_BITS-1:0]          req_item_key,
   output logic                         rsp_valid,
   output logic [$clog2(ITEMS)-1:0]     rsp_popped_index,
   output logic [KEY_BITS-1:0]          rsp_popped_key,
   output logic                         rsp_empty_flag,
   output logic [$clog2(ITEMS+1)-1:0]   rsp_entry_count
);
   localparam int IW = $clog2(ITEMS);
   localparam int CW = $clog2(ITEMS + 1);

   typedef enum logic [14:0] {
      S_CLR    = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_POS    = 15'b000000000000100,
      S_POPRT  = 15'b000000000001000,
      S_POPLS  = 15'b000000000010000,
      S_UPRD   = 15'b000000000100000,
      S_UPLD   = 15'b000000001000000,
      S_UPCMP  = 15'b000000010000000,
      S_DNRDL  = 15'b000000100000000,
      S_DNRDR  = 15'b000001000000000,
      S_DNRCMP = 15'b000010000000000,
      S_DNSEL  = 15'b000100000000000,
      S_DNCMP  = 15'b001000000000000,
      S_FIN    = 15'b010000000000000,
      S_DONE   = 15'b100000000000000
   } state_type;

   // memories: slot item/key by slot, position by item
   logic [IW-1:0]       item_mem [ITEMS];
   logic [KEY_BITS-1:0] key_mem  [ITEMS];
   logic [CW-1:0]       pos_mem  [ITEMS];

   state_type           state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [IW-1:0]       sweep_ff, sweep_in;
   logic [1:0]          mode_ff, mode_in;
   logic [IW-1:0]       it_ff, it_in;
   logic [KEY_BITS-1:0] key_ff, key_in;      // key of the moving entry
   logic [CW-1:0]       p_ff, p_in;          // hole position of moving entry
   logic [CW-1:0]       c_ff, c_in;          // partner position
   logic [IW-1:0]       c_item_ff, c_item_in;
   logic [KEY_BITS-1:0] c_key_ff, c_key_in;
   logic [IW-1:0]       r_item_ff, r_item_in;
   logic [KEY_BITS-1:0] r_key_ff, r_key_in;
   logic                upd_ff, upd_in;      // update path: try down if up did not move
   logic                moved_ff, moved_in;
   logic [IW-1:0]       pidx_ff, pidx_in;
   logic [KEY_BITS-1:0] pkey_ff, pkey_in;
   logic                empty_ff, empty_in;

   // memory port controls
   logic [IW-1:0]       rd_addr;
   logic [IW-1:0]       rd_item_q;
   logic [KEY_BITS-1:0] rd_key_q;
   logic [CW-1:0]       pr_q;
   logic                sw_en;
   logic [IW-1:0]       sw_addr, sw_item;
   logic [KEY_BITS-1:0] sw_key;
   logic                pw_en;
   logic [IW-1:0]       pw_addr;
   logic [CW-1:0]       pw_val;

   logic [KEY_BITS-1:0] cmp_a, cmp_b;
   imhq_pkg::cmp_rsp_type cmp_rsp;

   logic [CW:0]         lpos;

   imhq_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
      .clock (clock),
      .a_key (cmp_a),
      .b_key (cmp_b),
      .rsp   (cmp_rsp)
   );

   always_ff @(posedge clock) begin
      rd_item_q <= item_mem[rd_addr];
      rd_key_q  <= key_mem[rd_addr];
      pr_q      <= pos_mem[req_item_index];
      if (sw_en) begin
         item_mem[sw_addr] <= sw_item;
         key_mem[sw_addr]  <= sw_key;
      end
      if (pw_en) begin
         pos_mem[pw_addr] <= pw_val;
      end
   end

   assign lpos = {p_ff, 1'b0};

   // the moving entry stays in registers; each step moves the partner into the hole
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      sweep_in  = sweep_ff;
      mode_in   = mode_ff;
      it_in     = it_ff;
      key_in    = key_ff;
      p_in      = p_ff;
      c_in      = c_ff;
      c_item_in = c_item_ff;
      c_key_in  = c_key_ff;
      r_item_in = r_item_ff;
      r_key_in  = r_key_ff;
      upd_in    = upd_ff;
      moved_in  = moved_ff;
      pidx_in   = pidx_ff;
      pkey_in   = pkey_ff;
      empty_in  = empty_ff;
      rd_addr   = '0;
      sw_en     = 1'b0;
      sw_addr   = IW'(p_ff - CW'(1));
      sw_item   = c_item_ff;
      sw_key    = c_key_ff;
      pw_en     = 1'b0;
      pw_addr   = c_item_ff;
      pw_val    = p_ff;
      cmp_a     = key_ff;
      cmp_b     = c_key_ff;
      case (state_ff)
         S_CLR: begin
            pw_en    = 1'b1;
            pw_addr  = sweep_ff;
            pw_val   = '0;
            sweep_in = sweep_ff + IW'(1);
            if (sweep_ff == IW'(ITEMS - 1)) begin
               state_in = (mode_ff == imhq_pkg::MODE_CLEAR) ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               it_in    = req_item_index;
               key_in   = req_item_key;
               pidx_in  = '0;
               pkey_in  = '0;
               empty_in = 1'b0;
               moved_in = 1'b0;
               upd_in   = 1'b0;
               case (req_mode)
                  imhq_pkg::MODE_INSERT: state_in = S_POS;
                  imhq_pkg::MODE_POP: begin
                     if (fill_ff == '0) begin
                        empty_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_POPRT;   // root read issued at address zero
                     end
                  end
                  imhq_pkg::MODE_CLEAR: begin
                     fill_in  = '0;
                     sweep_in = '0;
                     state_in = S_CLR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_POS: begin
            // pr_q holds the item's position
            if (int'(it_ff) >= ITEMS) begin
               state_in = S_DONE;
            end else if (pr_q != '0 && pr_q <= fill_ff) begin
               p_in     = pr_q;
               upd_in   = 1'b1;
               state_in = S_UPRD;
            end else if (fill_ff < CW'(ITEMS)) begin
               fill_in  = fill_ff + CW'(1);
               p_in     = fill_ff + CW'(1);
               state_in = S_UPRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_POPRT: begin
            pidx_in  = rd_item_q;
            pkey_in  = rd_key_q;
            pw_en    = 1'b1;
            pw_addr  = rd_item_q;
            pw_val   = '0;
            fill_in  = fill_ff - CW'(1);
            rd_addr  = IW'(fill_ff - CW'(1));
            state_in = (fill_ff == CW'(1)) ? S_DONE : S_POPLS;
         end
         S_POPLS: begin
            // last entry becomes the moving entry at the root
            it_in    = rd_item_q;
            key_in   = rd_key_q;
            p_in     = CW'(1);
            state_in = S_DNRDL;
         end
         S_UPRD: begin
            if (p_ff == CW'(1)) begin
               state_in = (upd_ff && !moved_ff) ? S_DNRDL : S_FIN;
            end else begin
               rd_addr  = IW'((p_ff >> 1) - CW'(1));
               state_in = S_UPLD;
            end
         end
         S_UPLD: begin
            c_item_in = rd_item_q;
            c_key_in  = rd_key_q;
            cmp_b     = rd_key_q;
            state_in  = S_UPCMP;
         end
         S_UPCMP: begin
            if (cmp_rsp.gt) begin
               sw_en    = 1'b1;
               pw_en    = 1'b1;
               p_in     = p_ff >> 1;
               moved_in = 1'b1;
               state_in = S_UPRD;
            end else begin
               state_in = (upd_ff && !moved_ff) ? S_DNRDL : S_FIN;
            end
         end
         S_DNRDL: begin
            if (lpos > {1'b0, fill_ff}) begin
               state_in = S_FIN;
            end else begin
               rd_addr  = IW'(lpos - (CW+1)'(1));
               state_in = S_DNRDR;
            end
         end
         S_DNRDR: begin
            c_item_in = rd_item_q;
            c_key_in  = rd_key_q;
            c_in      = CW'(lpos);
            if (lpos < {1'b0, fill_ff}) begin
               rd_addr  = IW'(lpos);
               state_in = S_DNRCMP;
            end else begin
               cmp_a    = rd_key_q;
               cmp_b    = key_ff;
               state_in = S_DNCMP;
            end
         end
         S_DNRCMP: begin
            // right against left; left wins a tie
            r_item_in = rd_item_q;
            r_key_in  = rd_key_q;
            cmp_a     = rd_key_q;
            cmp_b     = c_key_ff;
            state_in  = S_DNSEL;
         end
         S_DNSEL: begin
            cmp_b = key_ff;
            if (cmp_rsp.gt) begin
               c_in      = c_ff + CW'(1);
               c_item_in = r_item_ff;
               c_key_in  = r_key_ff;
               cmp_a     = r_key_ff;
            end else begin
               cmp_a     = c_key_ff;
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (cmp_rsp.gt) begin
               sw_en    = 1'b1;
               pw_en    = 1'b1;
               p_in     = c_ff;
               state_in = S_DNRDL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            sw_en    = 1'b1;
            sw_item  = it_ff;
            sw_key   = key_ff;
            pw_en    = 1'b1;
            pw_addr  = it_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         fill_ff  <= '0;
         sweep_ff <= '0;
         mode_ff  <= imhq_pkg::MODE_INSERT;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         sweep_ff <= sweep_in;
         mode_ff  <= mode_in;
      end
      it_ff     <= it_in;
      key_ff    <= key_in;
      p_ff      <= p_in;
      c_ff      <= c_in;
      c_item_ff <= c_item_in;
      c_key_ff  <= c_key_in;
      r_item_ff <= r_item_in;
      r_key_ff  <= r_key_in;
      upd_ff    <= upd_in;
      moved_ff  <= moved_in;
      pidx_ff   <= pidx_in;
      pkey_ff   <= pkey_in;
      empty_ff  <= empty_in;
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = state_ff == S_DONE;
   assign rsp_popped_index = pidx_ff;
   assign rsp_popped_key   = pkey_ff;
   assign rsp_empty_flag   = empty_ff;
   assign rsp_entry_count  = fill_ff;

   `include "indexed_max_heap_queue_assert.svh"
   `IMHQ_ASSERT_NEXT(a_done_once, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `IMHQ_ASSERT_IMPL(a_fill_max, 1'b1, fill_ff <= CW'(ITEMS), "fill count past capacity")
   `IMHQ_ASSERT_IMPL(a_empty_zero, rsp_valid && rsp_empty_flag,
      rsp_popped_key == '0 && rsp_entry_count == '0, "empty pop with data")
   `IMHQ_ASSERT_IMPL(a_busy_rsp, rsp_valid, busy, "result strobe while idle")
endmodule

// ===== sim/indexed_max_heap_queue_tb.sv =====
// Self-checking testbench for the indexed max-heap queue: directed and random command stream, heap predictor
`timescale 1ns / 100ps
module indexed_max_heap_queue_tb;

   localparam int ITEMS    = 1024;
   localparam int KEY_BITS = 32;
   localparam int IW       = 10;
   localparam int CW       = 11;

   typedef struct {
      logic [1:0]          mode;
      logic [IW-1:0]       index;
      logic [KEY_BITS-1:0] key;
   } heap_cmd_type;

   typedef struct {
      logic [IW-1:0]       index;
      logic [KEY_BITS-1:0] key;
      logic                empty;
      logic [CW-1:0]       count;
   } heap_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_mode = imhq_pkg::MODE_INSERT;
   logic [IW-1:0]       req_item_index = '0;
   logic [KEY_BITS-1:0] req_item_key = '0;
   logic                rsp_valid;
   logic [IW-1:0]       rsp_popped_index;
   logic [KEY_BITS-1:0] rsp_popped_key;
   logic                rsp_empty_flag;
   logic [CW-1:0]       rsp_entry_count;

   indexed_max_heap_queue #(.ITEMS(ITEMS), .KEY_BITS(KEY_BITS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_item_index(req_item_index), .req_item_key(req_item_key),
      .rsp_valid(rsp_valid), .rsp_popped_index(rsp_popped_index),
      .rsp_popped_key(rsp_popped_key), .rsp_empty_flag(rsp_empty_flag),
      .rsp_entry_count(rsp_entry_count)
   );

   // predictor state; heap position p lives in slot p-1
   logic [IW-1:0]       slot_id  [ITEMS];
   logic [KEY_BITS-1:0] slot_pri [ITEMS];
   logic [CW-1:0]       id_pos   [ITEMS];
   int                  heap_size;

   heap_cmd_type  cmd_queue[$];
   heap_word_type expected_words[$];
   int            errors = 0;
   int            pops_seen = 0;
   int            empties_seen = 0;
   int            words_seen = 0;
   bit            hold_off = 1'b0;
   int            gap = 0;

   initial forever #6 clock = ~clock;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void swap_slots(int a, int b);
      logic [IW-1:0]       ti;
      logic [KEY_BITS-1:0] tk;
      ti = slot_id[a-1];  tk = slot_pri[a-1];
      slot_id[a-1] = slot_id[b-1];  slot_pri[a-1] = slot_pri[b-1];
      slot_id[b-1] = ti;  slot_pri[b-1] = tk;
      id_pos[slot_id[a-1]] = CW'(a);
      id_pos[slot_id[b-1]] = CW'(b);
   endfunction

   function automatic int bubble_up(int p);
      while (p > 1 && slot_pri[p-1] > slot_pri[(p>>1)-1]) begin
         swap_slots(p, p >> 1);
         p = p >> 1;
      end
      return p;
   endfunction

   function automatic void bubble_down(int p);
      int l;
      int c;
      forever begin
         l = p * 2;
         if (l > heap_size) return;
         c = l;
         if (l + 1 <= heap_size && slot_pri[l] > slot_pri[l-1]) c = l + 1;
         if (!(slot_pri[c-1] > slot_pri[p-1])) return;
         swap_slots(p, c);
         p = c;
      end
   endfunction

   function automatic heap_word_type heap_apply(heap_cmd_type c);
      heap_word_type w;
      int pos;
      w = '{index: '0, key: '0, empty: 1'b0, count: '0};
      if (c.mode == imhq_pkg::MODE_INSERT) begin
         pos = id_pos[c.index];
         if (pos >= 1 && pos <= heap_size) begin
            slot_pri[pos-1] = c.key;
            if (bubble_up(pos) == pos) bubble_down(pos);
         end else if (heap_size < ITEMS) begin
            heap_size++;
            slot_id[heap_size-1] = c.index;
            slot_pri[heap_size-1] = c.key;
            id_pos[c.index] = CW'(heap_size);
            void'(bubble_up(heap_size));
         end
      end else if (c.mode == imhq_pkg::MODE_POP) begin
         if (heap_size == 0) begin
            w.empty = 1'b1;
         end else begin
            w.index = slot_id[0];
            w.key = slot_pri[0];
            id_pos[slot_id[0]] = '0;
            heap_size--;
            if (heap_size > 0) begin
               slot_id[0] = slot_id[heap_size];
               slot_pri[0] = slot_pri[heap_size];
               id_pos[slot_id[0]] = CW'(1);
               bubble_down(1);
            end
         end
      end else if (c.mode == imhq_pkg::MODE_CLEAR) begin
         foreach (id_pos[i]) id_pos[i] = '0;
         heap_size = 0;
      end
      w.count = CW'(heap_size);
      return w;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [KEY_BITS-1:0] rand_key();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   task automatic push_cmd(input logic [1:0] m, input int idx, input logic [KEY_BITS-1:0] k);
      cmd_queue.push_back('{mode: m, index: idx[IW-1:0], key: k});
   endtask

   // stimulus
   initial begin
      int mode_pick;
      int pool;
      foreach (id_pos[i]) id_pos[i] = '0;
      heap_size = 0;
      // directed: empty pop, extremes, ties, update up/down, unused mode, clear
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_INSERT, 0, '0);
      push_cmd(imhq_pkg::MODE_INSERT, ITEMS - 1, '1);
      push_cmd(imhq_pkg::MODE_INSERT, 5, 32'h8000_0000);
      push_cmd(imhq_pkg::MODE_INSERT, 6, 32'h8000_0000);
      push_cmd(imhq_pkg::MODE_INSERT, 7, 32'h8000_0000);
      push_cmd(imhq_pkg::MODE_INSERT, 0, 32'hFFFF_FFFF);
      push_cmd(imhq_pkg::MODE_INSERT, ITEMS - 1, 32'h0000_0001);
      push_cmd(imhq_pkg::MODE_NOP, 9, 32'h1234_5678);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_INSERT, 0, 32'h7);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_INSERT, 300, 32'h5555_AAAA);
      push_cmd(imhq_pkg::MODE_INSERT, 683, 32'hAAAA_5555);
      push_cmd(imhq_pkg::MODE_CLEAR, 1023, '1);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      push_cmd(imhq_pkg::MODE_INSERT, 300, 32'h1);
      push_cmd(imhq_pkg::MODE_POP, 0, 0);
      // random: mostly inserts/updates from an id pool that alternates small and full, pops, rare clears
      for (int n = 0; n < 600; n++) begin
         mode_pick = $urandom_range(0, 99);
         pool = (n % 200 < 100) ? 15 : ITEMS - 1;
         if (mode_pick < 55)
            push_cmd(imhq_pkg::MODE_INSERT, $urandom_range(0, pool), rand_key());
         else if (mode_pick < 95)
            push_cmd(imhq_pkg::MODE_POP, $urandom_range(0, ITEMS - 1), $urandom());
         else if (mode_pick < 97)
            push_cmd(imhq_pkg::MODE_CLEAR, $urandom_range(0, ITEMS - 1), $urandom());
         else
            push_cmd(imhq_pkg::MODE_NOP, $urandom_range(0, ITEMS - 1), $urandom());
      end
   end

   // driver
   int sent = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // accepted this edge
         expected_words.push_back(heap_apply(cmd_queue.pop_front()));
         sent++;
         start <= 1'b0;
         gap <= pick_gap();
         if (sent == 300) hold_off <= 1'b1;
      end else if (!start) begin
         if (hold_off) begin
            if (expected_words.size() == 0) hold_off <= 1'b0;
         end else if (gap > 0) begin
            gap <= gap - 1;
         end else if (cmd_queue.size() > 0) begin
            req_mode <= cmd_queue[0].mode;
            req_item_index <= cmd_queue[0].index;
            req_item_key <= cmd_queue[0].key;
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      heap_word_type w;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            report("unexpected word", rsp_entry_count, -1);
         end else begin
            w = expected_words.pop_front();
            if (rsp_popped_index !== w.index) report("popped_index", rsp_popped_index, w.index);
            if (rsp_popped_key !== w.key) report("popped_key", rsp_popped_key, w.key);
            if (rsp_empty_flag !== w.empty) report("empty_flag", rsp_empty_flag, w.empty);
            if (rsp_entry_count !== w.count) report("entry_count", rsp_entry_count, w.count);
            if (w.empty) empties_seen++;
            else if (w.index != '0 || w.key != '0) pops_seen++;
         end
      end
   end

   // end of run
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (cmd_queue.size() == 0 && !start && sent > 0);
      wait (expected_words.size() == 0);
      repeat (2 * ITEMS + 100) @(posedge clock);
      $display("covered %0d commands, %0d result words, %0d pops with data, %0d empty pops",
               sent, words_seen, pops_seen, empties_seen);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("[indexed_max_heap_queue] OK");
      end else begin
         if (expected_words.size() != 0) report("words left over", expected_words.size(), 0);
         $display("[indexed_max_heap_queue] ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("[indexed_max_heap_queue] ERROR");
      $finish;
   end
endmodule
